[sv/four_channel_pwm_generator_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the four channel PWM generator
// Shared property forms; each use sits on a line of its own.
// ---------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_PWM_GENERATOR_UNIT_ASSERT_SVH
`define FOUR_CHANNEL_PWM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FCPWM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FCPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fcpwm_pkg.sv]
// ---------------------------------------------------------------------------
// fcpwm_pkg
// Widths, register map and lane handshake types of the PWM generator.
// ---------------------------------------------------------------------------
package fcpwm_pkg;

   localparam int CHANNELS   = 4;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int CNT_W      = 12;
   localparam int FREQ_W     = 8;
   localparam int DUTY_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int STEP_W     = $clog2(CNT_W);

   localparam logic [STEP_W-1:0]    STEP_LAST      = STEP_W'(CNT_W - 1);
   localparam logic [DUTY_W-1:0]    DUTY_MAX       = 7'd100;
   localparam logic [DUTY_W-1:0]    DUTY_RESET     = 7'd50;
   localparam logic [FREQ_W-1:0]    FREQ_RESET     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_BASE  = 3'd4;

   typedef struct packed {
      logic start;
      logic reload;
   } lane_req_type;

   typedef struct packed {
      logic done;
      logic level;
   } lane_rsp_type;

endpackage

[sv/fcpwm_div.sv]
// ---------------------------------------------------------------------------
// fcpwm_div
// Restoring divider, one quotient bit per cycle, CNT_W quotient bits per divide.
// ---------------------------------------------------------------------------
module fcpwm_div import fcpwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  dividend,
   input  logic [FREQ_W-1:0] divisor,
   output logic              done,
   output logic [CNT_W-1:0]  quotient
);

   logic              run_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  quo_ff;
   logic [FREQ_W-1:0] rem_ff;
   logic [FREQ_W-1:0] div_ff;

   logic [FREQ_W:0]   trial;
   logic [FREQ_W:0]   diff;
   logic              ge;
   logic [FREQ_W-1:0] rem_in;

   // shift the next dividend bit into the partial remainder
   assign trial  = {rem_ff, quo_ff[CNT_W-1]};
   assign diff   = trial - {1'b0, div_ff};
   assign ge     = trial >= {1'b0, div_ff};
   assign rem_in = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[CNT_W-2:0], ge};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/fcpwm_lane.sv]
// ---------------------------------------------------------------------------
// fcpwm_lane
// One channel: period and high count reload through a serial divider, and
// the tick counter with its level compare.
// ---------------------------------------------------------------------------
module fcpwm_lane import fcpwm_pkg::*; #(
   parameter int TICKS_PER_SECOND = 4000
) (
   input  logic              clock,
   input  logic              reset,
   input  lane_req_type      lane_req,
   input  logic [FREQ_W-1:0] freq,
   input  logic [DUTY_W-1:0] duty,
   output lane_rsp_type      lane_rsp
);

`include "four_channel_pwm_generator_unit_assert.svh"

   localparam logic [CNT_W-1:0] PERIOD_DIVIDEND = CNT_W'(TICKS_PER_SECOND);
   localparam logic [CNT_W-1:0] TICK_UNIT       = CNT_W'(TICKS_PER_SECOND / 100);

   typedef enum logic [1:0] {
      L_IDLE,
      L_PERIOD,
      L_HIGH,
      L_TICK
   } lane_state_type;

   lane_state_type   state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] period_ff;
   logic [CNT_W-1:0] high_ff;
   logic             zero_ff;
   logic             done_ff;
   logic             level_ff;

   logic [DUTY_W-1:0] duty_sat;
   logic [CNT_W-1:0]  high_dividend;
   logic [CNT_W-1:0]  cnt_inc;
   logic [CNT_W-1:0]  cnt_tick;
   logic              level_tick;
   logic              div_start;
   logic [CNT_W-1:0]  div_dividend;
   logic              div_done;
   logic [CNT_W-1:0]  div_quotient;

   assign duty_sat      = (duty > DUTY_MAX) ? DUTY_MAX : duty;
   assign high_dividend = TICK_UNIT * {{(CNT_W-DUTY_W){1'b0}}, duty_sat};

   // advance, then clear once at or past the period
   assign cnt_inc    = cnt_ff + 1'b1;
   assign cnt_tick   = (cnt_inc >= period_ff) ? '0 : cnt_inc;
   assign level_tick = cnt_tick < high_ff;

   assign div_start    = (state_ff == L_IDLE && lane_req.start && lane_req.reload)
                      || (state_ff == L_PERIOD && div_done);
   assign div_dividend = (state_ff == L_IDLE) ? PERIOD_DIVIDEND : high_dividend;

   fcpwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (freq),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         cnt_ff    <= '0;
         period_ff <= '0;
         high_ff   <= '0;
         zero_ff   <= 1'b0;
         done_ff   <= 1'b0;
         level_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (lane_req.start) begin
                  if (lane_req.reload) begin
                     zero_ff  <= (freq == '0);
                     state_ff <= L_PERIOD;
                  end else begin
                     cnt_ff   <= cnt_tick;
                     level_ff <= level_tick;
                     done_ff  <= 1'b1;
                  end
               end
            end
            L_PERIOD: begin
               if (div_done) begin
                  period_ff <= zero_ff ? '0 : div_quotient;
                  state_ff  <= L_HIGH;
               end
            end
            L_HIGH: begin
               if (div_done) begin
                  high_ff  <= zero_ff ? '0 : div_quotient;
                  state_ff <= L_TICK;
               end
            end
            L_TICK: begin
               cnt_ff   <= cnt_tick;
               level_ff <= level_tick;
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign lane_rsp.done  = done_ff;
   assign lane_rsp.level = level_ff;

   `FCPWM_ASSERT_IMPLY(a_level_needs_high, clock, reset, done_ff && level_ff, high_ff != '0, "lane high with zero high count")
   `FCPWM_ASSERT_IMPLY(a_count_in_period, clock, reset, done_ff, cnt_ff < period_ff || cnt_ff == '0, "lane count past period")

endmodule

[sv/fcpwm_merge.sv]
// ---------------------------------------------------------------------------
// fcpwm_merge
// Collects the lane levels into one result beat and holds it for the
// receiver.
// ---------------------------------------------------------------------------
module fcpwm_merge import fcpwm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  lane_rsp_type [CHANNELS-1:0] lane_rsp,
   input  logic                        load,
   input  logic                        rsp_stall,
   output logic                        all_done,
   output logic                        slot_free,
   output logic                        rsp_valid,
   output logic [CHANNELS-1:0]         levels
);

`include "four_channel_pwm_generator_unit_assert.svh"

   logic                rsp_valid_ff;
   logic [CHANNELS-1:0] levels_ff;
   logic [CHANNELS-1:0] done_vec;
   logic [CHANNELS-1:0] level_vec;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         done_vec[i]  = lane_rsp[i].done;
         level_vec[i] = lane_rsp[i].level;
      end
   end

   assign all_done  = &done_vec;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         levels_ff <= level_vec;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign levels    = levels_ff;

   `FCPWM_ASSERT_IMPLY(a_lanes_in_step, clock, reset, |done_vec, &done_vec, "lanes finished out of step")
   `FCPWM_ASSERT_IMPLY(a_load_into_free, clock, reset, load, slot_free, "result loaded over a waiting beat")

endmodule

[sv/four_channel_pwm_generator_unit.sv]
// ---------------------------------------------------------------------------
// four_channel_pwm_generator_unit
// Four tick-driven PWM channels with per-channel frequency and duty.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one beat is one tick; req_reload first recomputes every
//   channel's period (TICKS_PER_SECOND / freq) and high count
//   (TICKS_PER_SECOND/100 * duty / freq) before the tick is applied.
//   rsp channel: one beat per tick with the four channel levels after it.
//   csr port: indexes 0..3 write freq_ch0..3, 4..7 write duty_ch0..3;
//   a new setting takes effect at the next reload. Frequency zero holds a
//   channel low, duty above 100 counts as 100.
//   Timing: a plain tick is registered in each lane, then the merge
//   registers its rsp beat; a new tick is not taken until that beat is
//   loaded. A reload tick first runs two serial 12-bit divides per lane
//   (all lanes in parallel) and then applies the tick as a plain one.
//   Reset clears counters, periods and high counts (all levels low until the
//   first reload) and sets freq to 1 and duty to 50.
//   A stalled rsp beat holds; one more tick may be accepted and computed
//   meanwhile, then req_stall stays high until the beat is taken.
// ---------------------------------------------------------------------------
module four_channel_pwm_generator_unit import fcpwm_pkg::*; #(
   parameter int TICKS_PER_SECOND = 4000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_reload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_level_ch0,
   output logic                  rsp_level_ch1,
   output logic                  rsp_level_ch2,
   output logic                  rsp_level_ch3,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "four_channel_pwm_generator_unit_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_DELIVER
   } top_state_type;

   top_state_type state_ff;
   top_state_type state_in;

   logic [FREQ_W-1:0] freq_ff [CHANNELS];
   logic [DUTY_W-1:0] duty_ff [CHANNELS];

   lane_req_type                lane_req;
   lane_rsp_type [CHANNELS-1:0] lane_rsp;
   logic                        req_accept;
   logic                        all_done;
   logic                        slot_free;
   logic                        load;
   logic [CHANNELS-1:0]         levels;

   // registers: freq block below CSR_DUTY_BASE, duty block at and above; the low
   // index bits pick the channel in either block
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            freq_ff[i] <= FREQ_RESET;
            duty_ff[i] <= DUTY_RESET;
         end
      end else if (csr_write) begin
         if (csr_index < CSR_DUTY_BASE) begin
            freq_ff[csr_index[CH_W-1:0]] <= csr_wdata[FREQ_W-1:0];
         end else begin
            duty_ff[csr_index[CH_W-1:0]] <= csr_wdata[DUTY_W-1:0];
         end
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load       = (state_ff == S_DELIVER) && slot_free;

   assign lane_req.start  = req_accept;
   assign lane_req.reload = req_reload;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (all_done) begin
               state_in = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      fcpwm_lane #(
         .TICKS_PER_SECOND (TICKS_PER_SECOND)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_req (lane_req),
         .freq     (freq_ff[g]),
         .duty     (duty_ff[g]),
         .lane_rsp (lane_rsp[g])
      );
   end

   fcpwm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_rsp  (lane_rsp),
      .load      (load),
      .rsp_stall (rsp_stall),
      .all_done  (all_done),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .levels    (levels)
   );

   assign rsp_level_ch0 = levels[0];
   assign rsp_level_ch1 = levels[1];
   assign rsp_level_ch2 = levels[2];
   assign rsp_level_ch3 = levels[3];

   `FCPWM_ASSERT_IMPLY(a_done_while_busy, clock, reset, all_done, state_ff == S_BUSY, "lanes finished outside busy state")
   `FCPWM_ASSERT_NEXT(a_accept_goes_busy, clock, reset, req_accept, state_ff == S_BUSY, "accepted tick did not start lanes")

endmodule
